>>> sv/wms_pkg.sv
// Shared types and constants for the dual-channel window statistics block.
`timescale 1ns / 1ps
package wms_pkg;

    localparam int VAL_W   = 12;
    localparam int SUM_W   = 27;
    localparam int CNT_W   = 16;
    localparam int SHIFT_W = 4;
    localparam int CHAN_W  = 4;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 104;

    localparam logic [VAL_W-1:0]   VAL_MAX       = 12'hFFF;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET   = 4'd4;
    localparam logic [SHIFT_W-1:0] SHIFT_MIN     = 4'd1;
    localparam logic [4:0]         CNT_FULL_LOG2 = 5'd16;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [CHAN_W-1:0] CHAN_0 = 4'd0;
    localparam logic [CHAN_W-1:0] CHAN_1 = 4'd1;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [VAL_W-1:0] max;
        logic [VAL_W-1:0] min;
    } t_stats;

    typedef struct packed {
        logic             sample;
        logic             read_clr;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] win_len;
    } t_chan_ctrl;

endpackage

>>> sv/wms_chan.sv
// Per-channel running and latched minimum, maximum and sum over a window.
`timescale 1ns / 1ps
module wms_chan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wms_pkg::t_chan_ctrl i_ctrl,
    output wms_pkg::t_stats     o_latched
);
    import wms_pkg::*;

    logic [SUM_W-1:0] r_run_sum, n_run_sum;
    logic [CNT_W-1:0] r_count, n_count;
    logic [VAL_W-1:0] r_run_min, n_run_min;
    logic [VAL_W-1:0] r_run_max, n_run_max;
    t_stats           r_lat, n_lat;

    logic [SUM_W-1:0] w_sum_inc;
    logic [CNT_W-1:0] w_cnt_inc;
    logic [VAL_W-1:0] w_min_upd;
    logic [VAL_W-1:0] w_max_upd;

    assign w_sum_inc = r_run_sum + SUM_W'(i_ctrl.value);
    assign w_cnt_inc = r_count + CNT_W'(1);
    assign w_min_upd = (i_ctrl.value < r_run_min) ? i_ctrl.value : r_run_min;
    assign w_max_upd = (i_ctrl.value > r_run_max) ? i_ctrl.value : r_run_max;

    always_comb begin
        n_run_sum = r_run_sum;
        n_count   = r_count;
        n_run_min = r_run_min;
        n_run_max = r_run_max;
        n_lat     = r_lat;
        if (i_ctrl.sample) begin
            if (w_cnt_inc >= i_ctrl.win_len) begin
                // window complete: latch and restart
                n_lat.sum = w_sum_inc;
                n_lat.min = w_min_upd;
                n_lat.max = w_max_upd;
                n_run_sum = '0;
                n_count   = '0;
                n_run_min = VAL_MAX;
                n_run_max = '0;
            end else begin
                n_run_sum = w_sum_inc;
                n_count   = w_cnt_inc;
                n_run_min = w_min_upd;
                n_run_max = w_max_upd;
            end
        end
        if (i_ctrl.read_clr) begin
            n_lat.min = VAL_MAX;
            n_lat.max = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_sum <= '0;
            r_count   <= '0;
            r_run_min <= VAL_MAX;
            r_run_max <= '0;
            r_lat.sum <= '0;
            r_lat.min <= VAL_MAX;
            r_lat.max <= '0;
        end else begin
            r_run_sum <= n_run_sum;
            r_count   <= n_count;
            r_run_min <= n_run_min;
            r_run_max <= n_run_max;
            r_lat     <= n_lat;
        end
    end

    assign o_latched = r_lat;

endmodule

>>> sv/dual_channel_window_min_max_sum_core.sv
// Top level: input register, two channel statistics units and result register.
//
// Usage:
//   Slave stream carries sample and read items; tuser says which. A sample on
//   channel 0 or 1 updates that channel's running sum, count, minimum and
//   maximum; once the count reaches 2^(16 - window_shift) the three values
//   are latched and the running set restarts. Samples on other channels are
//   dropped. A read item yields one result item on the master stream with
//   both channels' latched minimum, maximum and sum, then clears the latched
//   minima to 4095 and maxima to 0 (sums are kept).
//   A read item passes the input register and then the result register before
//   it shows on the master side; a stall can hold it between the two.
//   Throughput: one item per cycle unless a read waits for output space.
//   Reset clears all statistics, sets window_shift to 4 and empties both
//   registers. When the receiver stalls, the result register holds; samples
//   keep flowing, and a read waits in the input register until the result
//   register frees, which then holds off the slave side. The user must write
//   window_shift (i_cfg_wr_en / i_cfg_wr_data) only while idle; not enforced.
`timescale 1ns / 1ps
module dual_channel_window_min_max_sum_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [wms_pkg::SHIFT_W-1:0]      i_cfg_wr_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: sample_channel[3:0], sample_value[15:4]
    input  logic [wms_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: kind
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: ch0_min[11:0], ch0_max[23:12], ch0_sum[50:24],
    //        ch1_min[62:51], ch1_max[74:63], ch1_sum[101:75], zero[103:102]
    output logic [wms_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
    import wms_pkg::*;

    logic [SHIFT_W-1:0]    r_window_shift;
    logic                  r_in_valid;
    logic                  r_in_kind;
    logic [CHAN_W-1:0]     r_in_chan;
    logic [VAL_W-1:0]      r_in_value;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                  w_accept;
    logic                  w_advance;
    logic                  w_read;
    logic [SHIFT_W-1:0]    w_eff_shift;
    logic [CNT_W-1:0]      w_win_len;
    t_chan_ctrl            w_ctrl0, w_ctrl1;
    t_stats                w_lat0, w_lat1;

    // shift of zero behaves as one
    assign w_eff_shift = (r_window_shift == '0) ? SHIFT_MIN : r_window_shift;
    assign w_win_len   = CNT_W'(17'd1 << (CNT_FULL_LOG2 - 5'(w_eff_shift)));

    // a sample never waits; a read waits for a free result register
    assign w_advance = r_in_valid &&
                       (r_in_kind == KIND_SAMPLE || !r_out_valid || m_axis_tready);
    assign w_read    = w_advance && r_in_kind == KIND_READ;

    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        w_ctrl0.sample   = w_advance && r_in_kind == KIND_SAMPLE && r_in_chan == CHAN_0;
        w_ctrl0.read_clr = w_read;
        w_ctrl0.value    = r_in_value;
        w_ctrl0.win_len  = w_win_len;
        w_ctrl1.sample   = w_advance && r_in_kind == KIND_SAMPLE && r_in_chan == CHAN_1;
        w_ctrl1.read_clr = w_read;
        w_ctrl1.value    = r_in_value;
        w_ctrl1.win_len  = w_win_len;
    end

    wms_chan u_chan0 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl0),
        .o_latched (w_lat0)
    );

    wms_chan u_chan1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl1),
        .o_latched (w_lat1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_shift <= SHIFT_RESET;
        end else if (i_cfg_wr_en) begin
            r_window_shift <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_kind  <= s_axis_tuser;
            r_in_chan  <= s_axis_tdata[CHAN_W-1:0];
            r_in_value <= s_axis_tdata[CHAN_W +: VAL_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_read) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_read) begin
            r_out_data <= {2'b00,
                           w_lat1.sum, w_lat1.max, w_lat1.min,
                           w_lat0.sum, w_lat0.max, w_lat0.min};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // a read always produces a result in the next cycle
    a_read_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_read |=> m_axis_tvalid)
        else $error("read item did not produce a result");

    // a fresh result only ever comes from a read item
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(w_read))
        else $error("result appeared without a read item");

    // a read leaves both channels' latched extremes cleared
    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_read |=> (w_lat0.min == VAL_MAX && w_lat0.max == '0 &&
                    w_lat1.min == VAL_MAX && w_lat1.max == '0))
        else $error("latched minimum or maximum not cleared after read");

    // samples are never held back by a stalled result register
    a_sample_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && r_in_kind == KIND_SAMPLE |-> s_axis_tready)
        else $error("sample item stalled");

endmodule
